// ----- rtl/rrpc_pkg.sv -----
// Shared types, constants and the CRC-8 step for the RMAP reply checker.
// No dependencies; imported by every module under rtl/.
package rrpc_pkg;

    localparam int POS_W = 25;
    localparam int LEN_W = 24;

    localparam int DEF_MIN_REPLY_BYTES = 8;
    localparam int DEF_LENGTH_BITS     = 24;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    localparam logic [7:0] OWN_ADDR_RESET   = 8'hFE;
    localparam logic [7:0] RMAP_PROTOCOL_ID = 8'h01;
    localparam logic [7:0] CRC_POLY_REFL    = 8'hE0;

    // header byte positions
    localparam logic [POS_W-1:0] POS_ADDR     = POS_W'(0);
    localparam logic [POS_W-1:0] POS_PROTO    = POS_W'(1);
    localparam logic [POS_W-1:0] POS_INSTR    = POS_W'(2);
    localparam logic [POS_W-1:0] POS_STATUS   = POS_W'(3);
    localparam logic [POS_W-1:0] POS_TARGET   = POS_W'(4);
    localparam logic [POS_W-1:0] POS_TID_HI   = POS_W'(5);
    localparam logic [POS_W-1:0] POS_TID_LO   = POS_W'(6);
    localparam logic [POS_W-1:0] POS_LEN_HI   = POS_W'(8);
    localparam logic [POS_W-1:0] POS_LEN_LO   = POS_W'(10);
    localparam logic [POS_W-1:0] HDR_END_WR   = POS_W'(7);
    localparam logic [POS_W-1:0] HDR_END_RD   = POS_W'(11);
    localparam logic [POS_W-1:0] DATA_START   = POS_W'(12);

    localparam logic [POS_W-1:0] WRITE_REPLY_BYTES   = POS_W'(8);
    localparam logic [POS_W-1:0] READ_REPLY_OVERHEAD = POS_W'(13);

    localparam int INSTR_CMD_BIT   = 6;
    localparam int INSTR_WRITE_BIT = 5;

    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef enum logic [1:0] {
        VERDICT_SUCCESS  = 2'd0,
        VERDICT_INVALID  = 2'd1,
        VERDICT_ADDR_BAD = 2'd2,
        VERDICT_CRC_BAD  = 2'd3
    } t_verdict;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       end_of_packet;
    } t_in_item;

    typedef struct packed {
        logic             result_kind;
        logic [7:0]       payload_byte;
        t_verdict         verdict;
        logic [7:0]       reply_status;
        logic [7:0]       target_address;
        logic [15:0]      transaction_id;
        logic [LEN_W-1:0] reply_data_length;
        logic [7:0]       instruction_byte;
        logic             was_write_reply;
    } t_out_item;

    // RMAP CRC-8, reflected 0x07, one byte
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- rtl/rrpc_parser.sv -----
// Per-packet state of the RMAP reply checker: header capture, CRC, position
// count and the end-of-packet verdict. Depends on rrpc_pkg.
module rrpc_parser
    import rrpc_pkg::*;
#(
    parameter int MIN_REPLY_BYTES = DEF_MIN_REPLY_BYTES,
    parameter int LENGTH_BITS     = DEF_LENGTH_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  t_in_item   i_item,
    input  logic [7:0] i_own_addr,
    output logic       o_emit,
    output t_out_item  o_result
);

    localparam logic [LEN_W-1:0] LenMask   = {LEN_W{1'b1}} >> (LEN_W - LENGTH_BITS);
    localparam logic [POS_W-1:0] MinReply  = POS_W'(MIN_REPLY_BYTES);

    logic [POS_W-1:0] r_pos,   n_pos;
    logic [7:0]       r_crc,   n_crc;
    logic             r_amis,  n_amis;
    logic             r_pbad,  n_pbad;
    logic             r_hbad,  n_hbad;
    logic             r_dbad,  n_dbad;
    logic [7:0]       r_instr, n_instr;
    logic [7:0]       r_stat,  n_stat;
    logic [7:0]       r_tgt,   n_tgt;
    logic [15:0]      r_tid,   n_tid;
    logic [LEN_W-1:0] r_len,   n_len;

    logic       n_emit;
    t_out_item  n_result;

    always_comb begin
        logic [7:0]       b;
        logic [POS_W-1:0] pos, hdr_end, data_end, total;
        logic             at_start, is_cmd, is_write, is_rd_reply, fwd;
        logic [7:0]       crc_base, crc_next;
        t_verdict         v;

        b        = i_item.packet_byte;
        pos      = r_pos;
        at_start = (pos == POS_ADDR);

        // a new packet starts from cleared state
        crc_base = at_start ? 8'd0 : r_crc;
        n_amis   = at_start ? (b != i_own_addr) : r_amis;
        n_pbad   = at_start ? 1'b0 : r_pbad;
        n_hbad   = at_start ? 1'b0 : r_hbad;
        n_dbad   = at_start ? 1'b0 : r_dbad;
        n_instr  = at_start ? 8'd0 : r_instr;
        n_stat   = at_start ? 8'd0 : r_stat;
        n_tgt    = at_start ? 8'd0 : r_tgt;
        n_tid    = at_start ? 16'd0 : r_tid;
        n_len    = at_start ? '0 : r_len;

        if (pos == POS_PROTO) begin
            n_pbad = (b != RMAP_PROTOCOL_ID);
        end
        if (pos == POS_INSTR) begin
            n_instr = b;
        end
        if (pos == POS_STATUS) begin
            n_stat = b;
        end
        if (pos == POS_TARGET) begin
            n_tgt = b;
        end
        if (pos == POS_TID_HI || pos == POS_TID_LO) begin
            n_tid = {n_tid[7:0], b};
        end
        if (pos >= POS_LEN_HI && pos <= POS_LEN_LO) begin
            n_len = {n_len[LEN_W-9:0], b};
            if (pos == POS_LEN_LO) begin
                n_len = n_len & LenMask;
            end
        end

        is_cmd      = n_instr[INSTR_CMD_BIT];
        is_write    = n_instr[INSTR_WRITE_BIT];
        is_rd_reply = !is_cmd && !is_write;
        hdr_end     = is_write ? HDR_END_WR : HDR_END_RD;
        data_end    = DATA_START + POS_W'(n_len);

        crc_next = crc8_update(crc_base, b);
        n_crc    = crc_base;
        fwd      = 1'b0;
        if (pos < hdr_end) begin
            n_crc = crc_next;
        end else if (pos == hdr_end) begin
            n_hbad = (b != crc_base);
            n_crc  = 8'd0;
        end else if (!is_write) begin
            if (pos < data_end) begin
                n_crc = crc_next;
                fwd   = is_rd_reply && !n_amis && !n_pbad;
            end else if (pos == data_end) begin
                n_dbad = (b != crc_base);
            end
        end

        total = (pos < POS_MAX) ? pos + POS_W'(1) : POS_MAX;

        // first failing check decides
        if (total < MinReply)                               v = VERDICT_INVALID;
        else if (n_amis)                                    v = VERDICT_ADDR_BAD;
        else if (n_pbad)                                    v = VERDICT_INVALID;
        else if (is_cmd)                                    v = VERDICT_SUCCESS;
        else if (is_write)
            v = (total != WRITE_REPLY_BYTES) ? VERDICT_INVALID
              : (n_hbad ? VERDICT_CRC_BAD : VERDICT_SUCCESS);
        else if (total < READ_REPLY_OVERHEAD)               v = VERDICT_INVALID;
        else if (n_hbad)                                    v = VERDICT_CRC_BAD;
        else if (POS_W'(n_len) + READ_REPLY_OVERHEAD != total) v = VERDICT_INVALID;
        else if (n_dbad)                                    v = VERDICT_CRC_BAD;
        else                                                v = VERDICT_SUCCESS;

        n_result.result_kind       = i_item.end_of_packet ? KIND_VERDICT : KIND_DATA;
        n_result.payload_byte      = i_item.end_of_packet ? 8'd0 : b;
        n_result.verdict           = i_item.end_of_packet ? v : VERDICT_SUCCESS;
        n_result.reply_status      = n_stat;
        n_result.target_address    = n_tgt;
        n_result.transaction_id    = n_tid;
        n_result.reply_data_length = is_rd_reply ? n_len : '0;
        n_result.instruction_byte  = n_instr;
        n_result.was_write_reply   = !is_cmd && is_write;

        n_emit = i_take && (i_item.end_of_packet || fwd);

        if (i_item.end_of_packet) begin
            n_pos = '0;
        end else begin
            n_pos = (pos < POS_MAX) ? pos + POS_W'(1) : POS_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_crc   <= '0;
            r_amis  <= 1'b0;
            r_pbad  <= 1'b0;
            r_hbad  <= 1'b0;
            r_dbad  <= 1'b0;
            r_instr <= '0;
            r_stat  <= '0;
            r_tgt   <= '0;
            r_tid   <= '0;
            r_len   <= '0;
        end else if (i_take) begin
            r_pos   <= n_pos;
            r_crc   <= i_item.end_of_packet ? 8'd0 : n_crc;
            r_amis  <= i_item.end_of_packet ? 1'b0 : n_amis;
            r_pbad  <= i_item.end_of_packet ? 1'b0 : n_pbad;
            r_hbad  <= i_item.end_of_packet ? 1'b0 : n_hbad;
            r_dbad  <= i_item.end_of_packet ? 1'b0 : n_dbad;
            r_instr <= i_item.end_of_packet ? 8'd0 : n_instr;
            r_stat  <= i_item.end_of_packet ? 8'd0 : n_stat;
            r_tgt   <= i_item.end_of_packet ? 8'd0 : n_tgt;
            r_tid   <= i_item.end_of_packet ? 16'd0 : n_tid;
            r_len   <= i_item.end_of_packet ? '0 : n_len;
        end
    end

    assign o_emit   = n_emit;
    assign o_result = n_result;

endmodule

// ----- rtl/rrpc_out_buf.sv -----
// Two-word result buffer; its fill level drives the upstream stall.
// Depends on rrpc_pkg.
module rrpc_out_buf
    import rrpc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_item i_data,
    output logic      o_full,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);

    t_out_item  r_buf [2];
    logic       r_head, n_head;
    logic [1:0] r_cnt,  n_cnt;
    logic       pop;
    logic       tail;

    assign pop  = (r_cnt != 2'd0) && !i_stall;
    assign tail = r_head ^ r_cnt[0];

    always_comb begin
        n_head = pop ? ~r_head : r_head;
        n_cnt  = r_cnt + 2'(i_push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_head <= n_head;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[tail] <= i_data;
        end
    end

    assign o_full  = r_cnt[1];
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_buf[r_head];

endmodule

// ----- rtl/rmap_reply_packet_checker.sv -----
// Top level of the RMAP reply packet checker: address register, parser, result buffer.
// Depends on rrpc_pkg, rrpc_parser, rrpc_out_buf.
//
//  port group                     dir  word
//  i_in_valid/o_in_stall          in   t_in_item: one packet byte + end mark
//  o_out_valid/i_out_stall        out  t_out_item: data byte or verdict
//  i_cfg_wr_en/i_cfg_wr_data      in   own logical address, 8 bits
//
// One byte per cycle unless stalled. A byte updates the packet state at the edge
// it is taken; its result (if any) lands in the two-word output buffer at that edge.
// o_in_stall is high while the buffer holds two words, and during reset.
// Synchronous active-low reset clears packet state and sets the address to 0xFE.
module rmap_reply_packet_checker
    import rrpc_pkg::*;
#(
    parameter int MIN_REPLY_BYTES = DEF_MIN_REPLY_BYTES,
    parameter int LENGTH_BITS     = DEF_LENGTH_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_item,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_item,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data
);

    logic [7:0] r_own_addr;
    logic       take;
    logic       emit;
    logic       full;
    t_out_item  result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_addr <= OWN_ADDR_RESET;
        end else if (i_cfg_wr_en) begin
            r_own_addr <= i_cfg_wr_data;
        end
    end

    assign o_in_stall = full || !i_rst_n;
    assign take       = i_in_valid && !o_in_stall;

    rrpc_parser #(
        .MIN_REPLY_BYTES (MIN_REPLY_BYTES),
        .LENGTH_BITS     (LENGTH_BITS)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_item     (i_in_item),
        .i_own_addr (r_own_addr),
        .o_emit     (emit),
        .o_result   (result)
    );

    rrpc_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (emit),
        .i_data  (result),
        .o_full  (full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_item)
    );

endmodule

// ----- tb/rmap_reply_packet_checker_test.sv -----
// Self-checking testbench for rmap_reply_packet_checker: builds RMAP reply packets,
// predicts forwarded data words and end-of-packet verdicts, and checks them in order.
// Depends on rrpc_pkg and the RTL under rtl/.
module rmap_reply_packet_checker_test
    import rrpc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int WORD_BUDGET = 1650;
    localparam int NUM_PHASES  = 5;
    localparam logic [LEN_W-1:0] LEN_MASK = LEN_W'((64'd1 << DEF_LENGTH_BITS) - 1);

    // Tracks packet state and queues the words the checker should produce.
    class reply_scoreboard;
        logic [7:0]       own_addr;
        logic [POS_W-1:0] byte_pos;
        logic [7:0]       crc_acc;
        bit               addr_bad;
        bit               proto_bad;
        bit               hdr_crc_bad;
        bit               data_crc_bad;
        logic [7:0]       instr;
        logic [7:0]       status;
        logic [7:0]       target;
        logic [15:0]      tid;
        logic [LEN_W-1:0] len;
        t_out_item        expected_q[$];
        int               errors;

        function new();
            own_addr = OWN_ADDR_RESET;
            errors = 0;
            clear_packet();
        endfunction

        static function logic [7:0] crc_step(logic [7:0] crc, logic [7:0] b);
            logic [7:0] c;
            c = crc ^ b;
            repeat (8) c = c[0] ? ({1'b0, c[7:1]} ^ CRC_POLY_REFL) : {1'b0, c[7:1]};
            return c;
        endfunction

        function void clear_packet();
            byte_pos = '0;
            crc_acc = '0;
            addr_bad = 0;
            proto_bad = 0;
            hdr_crc_bad = 0;
            data_crc_bad = 0;
            instr = '0;
            status = '0;
            target = '0;
            tid = '0;
            len = '0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_byte(logic [7:0] b, logic eop);
            logic [POS_W-1:0] pos;
            logic [POS_W-1:0] hdr_end;
            logic [POS_W-1:0] total;
            logic [POS_W:0]   data_end;
            bit               is_cmd;
            bit               is_wr;
            bit               is_rd;
            bit               fwd;
            t_out_item        r;
            t_verdict         v;
            pos = byte_pos;
            fwd = 0;
            if (pos == POS_ADDR) begin
                clear_packet();
                addr_bad = (b != own_addr);
            end else if (pos == POS_PROTO) begin
                proto_bad = (b != RMAP_PROTOCOL_ID);
            end else if (pos == POS_INSTR) begin
                instr = b;
            end else if (pos == POS_STATUS) begin
                status = b;
            end else if (pos == POS_TARGET) begin
                target = b;
            end else if (pos == POS_TID_HI || pos == POS_TID_LO) begin
                tid = {tid[7:0], b};
            end else if (pos >= POS_LEN_HI && pos <= POS_LEN_LO) begin
                len = {len[LEN_W-9:0], b};
                if (pos == POS_LEN_LO) len &= LEN_MASK;
            end

            is_cmd = instr[INSTR_CMD_BIT];
            is_wr = instr[INSTR_WRITE_BIT];
            is_rd = !is_cmd && !is_wr;
            hdr_end = is_wr ? HDR_END_WR : HDR_END_RD;
            data_end = {1'b0, DATA_START} + {2'b0, len};

            if (pos < hdr_end) begin
                crc_acc = crc_step(crc_acc, b);
            end else if (pos == hdr_end) begin
                hdr_crc_bad = (b != crc_acc);
                crc_acc = '0;
            end else if (!is_wr) begin
                if ({1'b0, pos} < data_end) begin
                    crc_acc = crc_step(crc_acc, b);
                    fwd = is_rd && !addr_bad && !proto_bad;
                end else if ({1'b0, pos} == data_end) begin
                    data_crc_bad = (b != crc_acc);
                end
            end

            if (byte_pos != POS_MAX) byte_pos++;
            if (!eop && !fwd) return;

            r = '0;
            r.reply_status = status;
            r.target_address = target;
            r.transaction_id = tid;
            r.reply_data_length = is_rd ? len : '0;
            r.instruction_byte = instr;
            r.was_write_reply = !is_cmd && is_wr;
            if (!eop) begin
                r.result_kind = KIND_DATA;
                r.payload_byte = b;
                r.verdict = VERDICT_SUCCESS;
            end else begin
                total = (pos != POS_MAX) ? pos + 1'b1 : POS_MAX;
                if (total < POS_W'(DEF_MIN_REPLY_BYTES))
                    v = VERDICT_INVALID;
                else if (addr_bad)
                    v = VERDICT_ADDR_BAD;
                else if (proto_bad)
                    v = VERDICT_INVALID;
                else if (is_cmd)
                    v = VERDICT_SUCCESS;
                else if (is_wr)
                    v = (total != WRITE_REPLY_BYTES) ? VERDICT_INVALID :
                        (hdr_crc_bad ? VERDICT_CRC_BAD : VERDICT_SUCCESS);
                else if (total < READ_REPLY_OVERHEAD)
                    v = VERDICT_INVALID;
                else if (hdr_crc_bad)
                    v = VERDICT_CRC_BAD;
                else if (({2'b0, len} + {1'b0, READ_REPLY_OVERHEAD}) != {1'b0, total})
                    v = VERDICT_INVALID;
                else if (data_crc_bad)
                    v = VERDICT_CRC_BAD;
                else
                    v = VERDICT_SUCCESS;
                r.result_kind = KIND_VERDICT;
                r.payload_byte = '0;
                r.verdict = v;
                clear_packet();
            end
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_q.size() == 0) begin
                $error("result word with none pending: kind %0d byte 0x%0h verdict %0d",
                       got.result_kind, got.payload_byte, got.verdict);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("result_kind", want.result_kind, got.result_kind);
            compare_field("payload_byte", want.payload_byte, got.payload_byte);
            compare_field("verdict", want.verdict, got.verdict);
            compare_field("reply_status", want.reply_status, got.reply_status);
            compare_field("target_address", want.target_address, got.target_address);
            compare_field("transaction_id", want.transaction_id, got.transaction_id);
            compare_field("reply_data_length", want.reply_data_length, got.reply_data_length);
            compare_field("instruction_byte", want.instruction_byte, got.instruction_byte);
            compare_field("was_write_reply", want.was_write_reply, got.was_write_reply);
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_in_item   i_in_item = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_item  o_out_item;
    logic       i_cfg_wr_en = 1'b0;
    logic [7:0] i_cfg_wr_data = '0;

    reply_scoreboard sb;
    logic [7:0]      pkt[$];
    bit              calm_in = 0;
    bit              calm_out = 0;
    int              words_sent = 0;
    int              cycle_count = 0;

    rmap_reply_packet_checker uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_item     (i_in_item),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_item    (o_out_item),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------- packet building ----------------

    function automatic logic [7:0] rand_byte();
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] nonzero_byte();
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic logic [7:0] rand_instr(bit cmd, bit wr);
        logic [7:0] v;
        v = rand_byte();
        v[INSTR_CMD_BIT] = cmd;
        v[INSTR_WRITE_BIT] = wr;
        return v;
    endfunction

    function automatic logic [7:0] crc_over(int first, int count);
        logic [7:0] c;
        c = '0;
        for (int i = first; i < first + count; i++) c = reply_scoreboard::crc_step(c, pkt[i]);
        return c;
    endfunction

    task automatic build_write(input bit bad_crc);
        pkt = {};
        pkt.push_back(sb.own_addr);
        pkt.push_back(RMAP_PROTOCOL_ID);
        pkt.push_back(rand_instr(0, 1));
        repeat (4) pkt.push_back(rand_byte());
        pkt.push_back(crc_over(0, 7) ^ (bad_crc ? nonzero_byte() : 8'h00));
    endtask

    task automatic build_read(input int actual, input logic [23:0] declared,
                              input bit bad_hdr, input bit bad_data);
        pkt = {};
        pkt.push_back(sb.own_addr);
        pkt.push_back(RMAP_PROTOCOL_ID);
        pkt.push_back(rand_instr(0, 0));
        repeat (5) pkt.push_back(rand_byte());   // status, target, tid, reserved
        pkt.push_back(declared[23:16]);
        pkt.push_back(declared[15:8]);
        pkt.push_back(declared[7:0]);
        pkt.push_back(crc_over(0, 11) ^ (bad_hdr ? nonzero_byte() : 8'h00));
        repeat (actual) pkt.push_back(rand_byte());
        pkt.push_back(crc_over(12, actual) ^ (bad_data ? nonzero_byte() : 8'h00));
    endtask

    task automatic build_command(input int n);
        pkt = {};
        pkt.push_back(sb.own_addr);
        pkt.push_back(RMAP_PROTOCOL_ID);
        pkt.push_back(rand_instr(1, $urandom_range(0, 1)));
        while (pkt.size() < n) pkt.push_back(rand_byte());
    endtask

    task automatic build_noise(input int n);
        pkt = {};
        repeat (n) pkt.push_back(rand_byte());
    endtask

    task automatic mutate();
        int idx;
        case ($urandom_range(0, 5))
            0: pkt[0] = pkt[0] ^ nonzero_byte();
            1: pkt[1] = rand_byte();
            2: if (pkt.size() > 1) begin
                idx = $urandom_range(1, pkt.size() - 1);
                while (pkt.size() > idx) void'(pkt.pop_back());
            end
            3: repeat ($urandom_range(1, 4)) pkt.push_back(rand_byte());
            4: begin
                idx = $urandom_range(0, pkt.size() - 1);
                pkt[idx] = pkt[idx] ^ nonzero_byte();
            end
            default: pkt[2] = pkt[2] ^ (8'h1 << ($urandom_range(0, 1) ? INSTR_CMD_BIT
                                                                     : INSTR_WRITE_BIT));
        endcase
    endtask

    function automatic int read_len();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(17, 120) : $urandom_range(0, 16);
    endfunction

    task automatic random_packet();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 28) begin
            build_write($urandom_range(0, 9) == 0);
        end else if (pick < 68) begin
            n = read_len();
            build_read(n, 24'(n), $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
        end else if (pick < 76) begin
            build_command($urandom_range(8, 24));
        end else if (pick < 92) begin
            if ($urandom_range(0, 1)) begin
                build_write(0);
            end else begin
                n = read_len();
                build_read(n, 24'(n), 0, 0);
            end
            mutate();
        end else begin
            build_noise($urandom_range(1, 20));
        end
    endtask

    // ---------------- driving ----------------

    task automatic send_word(input logic [7:0] b, input logic eop);
        int gap;
        gap = calm_in ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= {b, eop};
        do @(posedge i_clk); while (o_in_stall);
        sb.note_byte(b, eop);
        words_sent++;
    endtask

    task automatic send_packet();
        calm_in = ($urandom_range(0, 3) == 0);
        foreach (pkt[i]) send_word(pkt[i], i == pkt.size() - 1);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_own_address(input logic [7:0] a);
        wait_drained();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= a;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.own_addr = a;
    endtask

    // result side: random stall before each word, with calm stretches
    initial begin
        int hold;
        int n_results;
        n_results = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (n_results % 40 == 0) calm_out = ($urandom_range(0, 2) == 0);
            hold = calm_out ? 0 : $urandom_range(0, 12);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_out_valid);
            sb.check_result(o_out_item);
            n_results++;
        end
    end

    initial begin
        logic [7:0] phase_addr[NUM_PHASES];
        int         phase_end;
        int         phase_mid;
        bit         paused;
        sb = new();
        phase_addr[0] = 8'h00;
        phase_addr[1] = 8'hFF;
        phase_addr[2] = rand_byte();
        phase_addr[3] = rand_byte();
        phase_addr[4] = OWN_ADDR_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed packets at the reset address
        build_noise(1);                 pkt[0] = 8'h00;          send_packet();
        build_write(0);                 void'(pkt.pop_back());   send_packet();
        build_write(0);                                          send_packet();
        build_write(1);                                          send_packet();
        build_write(0);                 pkt.push_back(8'hFF);    send_packet();
        build_write(0);                 pkt[0] = pkt[0] ^ 8'h01; send_packet();
        build_write(0);                 pkt[1] = 8'h02;          send_packet();
        build_command(10);                                       send_packet();
        build_read(0, 24'd0, 0, 0);                              send_packet();
        build_read(5, 24'd5, 0, 0);                              send_packet();
        build_read(3, 24'd3, 1, 0);                              send_packet();
        build_read(6, 24'd4, 0, 0);                              send_packet();
        build_read(2, 24'd2, 0, 1);                              send_packet();
        build_read(0, 24'd0, 0, 0);     void'(pkt.pop_back());   send_packet();
        // declared length far beyond the packet: data still forwarded until the end
        build_read(4, 24'hFFFFFF, 0, 0);                         send_packet();
        build_noise(8);                 foreach (pkt[i]) pkt[i] = 8'hFF; send_packet();

        for (int p = 0; p < NUM_PHASES; p++) begin
            set_own_address(phase_addr[p]);
            phase_end = words_sent + WORD_BUDGET / NUM_PHASES;
            phase_mid = words_sent + $urandom_range(50, WORD_BUDGET / NUM_PHASES - 50);
            paused = 0;
            while (words_sent < phase_end) begin
                random_packet();
                send_packet();
                // sender holds off until every pending word is out
                if (!paused && words_sent >= phase_mid) begin
                    wait_drained();
                    paused = 1;
                end
            end
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/rrpc_pkg.sv
rtl/rrpc_parser.sv
rtl/rrpc_out_buf.sv
rtl/rmap_reply_packet_checker.sv
tb/rmap_reply_packet_checker_test.sv
